// ===== hdl/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dpw_pkg
// Shared types and constants of the depth pixel to world point core.
// ----------------------------------------------------------------------------
package dpw_pkg;

  localparam int POSE_W    = 32;
  localparam int DEPTH_W   = 16;
  localparam int OUT_W     = 32;
  localparam int QUO_W     = OUT_W + 1;
  localparam int NUM_LANES = 3;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;

  localparam int FOCAL_PX = 585;
  localparam int CENTER_X = 320;
  localparam int CENTER_Y = 240;
  localparam logic [19:0] W_TERM = 20'd585000;

  localparam logic [DEPTH_W-1:0] DEPTH_NONE = 16'hFFFF;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN  = 16'd100;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 16'd10000;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam logic [CFG_W-1:0] POSE_ONE_LO = 64'h0000_0000_0100_0000;
  localparam logic [CFG_W-1:0] POSE_ONE_HI = 64'h0100_0000_0000_0000;

  typedef struct packed {
    logic vld;
    logic pv;
  } item_ctl_t;

  function automatic logic [CFG_W-1:0] pose_reset(input int idx);
    logic [CFG_W-1:0] v;
    case (idx)
      0, 5:    v = POSE_ONE_LO;
      2, 7:    v = POSE_ONE_HI;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/dpw_backproj.sv =====
// ----------------------------------------------------------------------------
// dpw_backproj
// Depth range check and pinhole back-projection into scaled camera terms.
// ----------------------------------------------------------------------------
module dpw_backproj #(
  parameter int COORD_BITS = 10,
  parameter int PW = 29
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [COORD_BITS-1:0]     col,
  input  logic [COORD_BITS-1:0]     row,
  input  logic [dpw_pkg::DEPTH_W-1:0] depth,
  output dpw_pkg::item_ctl_t        ctl,
  output logic signed [PW-1:0]      p0,
  output logic signed [PW-1:0]      p1,
  output logic signed [PW-1:0]      p2
);
  import dpw_pkg::*;

  localparam int CW = COORD_BITS + 2;

  item_ctl_t               ctl1;
  logic signed [CW-1:0]    cx;
  logic signed [CW-1:0]    cy;
  logic [DEPTH_W-1:0]      d1;
  logic signed [PW-1:0]    ds;

  assign ds = PW'($signed({1'b0, d1}));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.vld <= 1'b0;
      ctl.vld  <= 1'b0;
    end else if (en) begin
      ctl1.vld <= in_vld;
      ctl.vld  <= ctl1.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1.pv <= (depth != DEPTH_NONE) && (depth >= DEPTH_MIN) && (depth <= DEPTH_MAX);
      cx      <= $signed({2'b00, col}) - CW'(CENTER_X);
      cy      <= $signed({2'b00, row}) - CW'(CENTER_Y);
      d1      <= depth;
      ctl.pv  <= ctl1.pv;
      p0      <= PW'(cx) * ds;
      p1      <= PW'(cy) * ds;
      p2      <= ds * PW'(FOCAL_PX);
    end
  end

endmodule

// ===== hdl/dpw_transform.sv =====
// ----------------------------------------------------------------------------
// dpw_transform
// Multiplies the homogeneous camera point by the pose: products, then a
// two-level registered adder tree per row.
// ----------------------------------------------------------------------------
module dpw_transform #(
  parameter int PW = 29,
  parameter int AW = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  dpw_pkg::item_ctl_t          ctl_in,
  input  logic signed [PW-1:0]        p0,
  input  logic signed [PW-1:0]        p1,
  input  logic signed [PW-1:0]        p2,
  input  logic [dpw_pkg::CFG_W-1:0]   pose [dpw_pkg::NUM_REGS],
  output dpw_pkg::item_ctl_t          ctl,
  output logic signed [AW-1:0]        acc [4]
);
  import dpw_pkg::*;

  localparam int MW = POSE_W + PW;

  item_ctl_t              ctl_a;
  item_ctl_t              ctl_b;
  logic signed [PW-1:0]   pt [4];
  logic signed [MW-1:0]   prod [4][4];
  logic signed [AW-1:0]   half [4][2];

  assign pt[0] = p0;
  assign pt[1] = p1;
  assign pt[2] = p2;
  assign pt[3] = PW'($signed({1'b0, W_TERM}));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.vld <= 1'b0;
      ctl_b.vld <= 1'b0;
      ctl.vld   <= 1'b0;
    end else if (en) begin
      ctl_a.vld <= ctl_in.vld;
      ctl_b.vld <= ctl_a.vld;
      ctl.vld   <= ctl_b.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_a.pv <= ctl_in.pv;
      ctl_b.pv <= ctl_a.pv;
      ctl.pv   <= ctl_b.pv;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= MW'($signed(pose[2*i + (j >> 1)][(j & 1)*POSE_W +: POSE_W]))
                        * MW'(pt[j]);
        end
        half[i][0] <= AW'(prod[i][0]) + AW'(prod[i][1]);
        half[i][1] <= AW'(prod[i][2]) + AW'(prod[i][3]);
        acc[i]     <= half[i][0] + half[i][1];
      end
    end
  end

endmodule

// ===== hdl/dpw_divider.sv =====
// ----------------------------------------------------------------------------
// dpw_divider
// Three-lane pipelined restoring divider with a shared denominator. One
// quotient bit per stage, then rounding to nearest and saturation.
// ----------------------------------------------------------------------------
module dpw_divider #(
  parameter int AW = 63,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  dpw_pkg::item_ctl_t            ctl_in,
  input  logic signed [AW-1:0]          num [dpw_pkg::NUM_LANES],
  input  logic signed [AW-1:0]          den,
  output dpw_pkg::item_ctl_t            ctl,
  output logic [dpw_pkg::OUT_W-1:0]     quo [dpw_pkg::NUM_LANES]
);
  import dpw_pkg::*;

  localparam int NQ   = QUO_W;
  localparam int ISH  = OUT_W - OUT_FRAC_BITS;

  item_ctl_t         ctl_p;
  logic [AW-1:0]     nm_p [NUM_LANES];
  logic              nn_p [NUM_LANES];
  logic              nz_p [NUM_LANES];
  logic [AW-1:0]     dm_p;
  logic              dn_p;

  item_ctl_t         sc   [0:NQ];
  logic [AW-1:0]     dm   [0:NQ];
  logic              dz   [0:NQ];
  logic [AW:0]       rr   [0:NQ][NUM_LANES];
  logic [QUO_W-1:0]  qq   [0:NQ][NUM_LANES];
  logic              ng   [0:NQ][NUM_LANES];
  logic              nneg [0:NQ][NUM_LANES];
  logic              nzer [0:NQ][NUM_LANES];
  logic              ov   [0:NQ][NUM_LANES];

  logic [AW:0]       rn   [1:NQ][NUM_LANES];
  logic              tk   [1:NQ][NUM_LANES];

  always_comb begin
    int          s;
    logic [AW:0] rs;
    logic [AW:0] dx;
    for (int j = 1; j <= NQ; j++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        s  = OUT_W - OUT_FRAC_BITS - j;
        dx = {1'b0, dm[j-1]};
        if (s >= 0) begin
          rs       = rr[j-1][l] >> s;
          tk[j][l] = rs >= dx;
          rn[j][l] = tk[j][l] ? rr[j-1][l] - (dx << s) : rr[j-1][l];
        end else begin
          rs       = rr[j-1][l] << 1;
          tk[j][l] = rs >= dx;
          rn[j][l] = tk[j][l] ? rs - dx : rs;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p.vld <= 1'b0;
      ctl.vld   <= 1'b0;
      for (int j = 0; j <= NQ; j++) begin
        sc[j].vld <= 1'b0;
      end
    end else if (en) begin
      ctl_p.vld <= ctl_in.vld;
      sc[0]     <= ctl_p;
      for (int j = 1; j <= NQ; j++) begin
        sc[j] <= sc[j-1];
      end
      ctl.vld <= sc[NQ].vld;
    end
  end

  always_ff @(posedge clk) begin
    logic [QUO_W-1:0] mag;
    if (en) begin
      ctl_p.pv <= ctl_in.pv;
      dm_p     <= den[AW-1] ? AW'(-den) : AW'(den);
      dn_p     <= den[AW-1];
      for (int l = 0; l < NUM_LANES; l++) begin
        nm_p[l] <= num[l][AW-1] ? AW'(-num[l]) : AW'(num[l]);
        nn_p[l] <= num[l][AW-1];
        nz_p[l] <= num[l] == '0;
      end

      dm[0]    <= dm_p;
      dz[0]    <= dm_p == '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        rr[0][l]   <= {1'b0, nm_p[l]};
        qq[0][l]   <= '0;
        ng[0][l]   <= nn_p[l] ^ dn_p;
        nneg[0][l] <= nn_p[l];
        nzer[0][l] <= nz_p[l];
        ov[0][l]   <= (nm_p[l] >> ISH) >= dm_p;
      end

      for (int j = 1; j <= NQ; j++) begin
        dm[j]    <= dm[j-1];
        dz[j]    <= dz[j-1];
        for (int l = 0; l < NUM_LANES; l++) begin
          rr[j][l]   <= rn[j][l];
          qq[j][l]   <= {qq[j-1][l][QUO_W-2:0], tk[j][l]};
          ng[j][l]   <= ng[j-1][l];
          nneg[j][l] <= nneg[j-1][l];
          nzer[j][l] <= nzer[j-1][l];
          ov[j][l]   <= ov[j-1][l];
        end
      end

      ctl.pv <= sc[NQ].pv;
      for (int l = 0; l < NUM_LANES; l++) begin
        mag = {1'b0, qq[NQ][l][QUO_W-1:1]} + QUO_W'(qq[NQ][l][0]);
        if (!sc[NQ].pv) begin
          quo[l] <= '0;
        end else if (dz[NQ]) begin
          quo[l] <= nzer[NQ][l] ? '0 : (nneg[NQ][l] ? SAT_NEG : SAT_POS);
        end else if (ov[NQ][l]) begin
          quo[l] <= ng[NQ][l] ? SAT_NEG : SAT_POS;
        end else if (ng[NQ][l]) begin
          quo[l] <= (mag > QUO_W'(SAT_NEG)) ? SAT_NEG : OUT_W'(-mag);
        end else begin
          quo[l] <= (mag > QUO_W'(SAT_POS)) ? SAT_POS : OUT_W'(mag);
        end
      end
    end
  end

endmodule

// ===== hdl/depth_pixel_to_world_point_core.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_core
// Back-projects a depth pixel and maps it through a configurable 4x4 pose
// into world coordinates in signed fixed point.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle unless the output stalls.
// The divider has one stage per quotient bit.
// A stall on the output while a result waits freezes the whole pipeline.
// Reset clears all valid bits and loads the identity pose.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_core #(
  parameter int COORD_BITS    = 10,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COORD_BITS-1:0]           pixel_col,
  input  logic [COORD_BITS-1:0]           pixel_row,
  input  logic [dpw_pkg::DEPTH_W-1:0]     depth_mm,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            point_valid,
  output logic signed [dpw_pkg::OUT_W-1:0] world_x,
  output logic signed [dpw_pkg::OUT_W-1:0] world_y,
  output logic signed [dpw_pkg::OUT_W-1:0] world_z,
  input  logic                            cfg_we,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpw_pkg::CFG_W-1:0]       cfg_data
);
  import dpw_pkg::*;

  localparam int PW = (COORD_BITS + 19 > 27) ? COORD_BITS + 19 : 27;
  localparam int AW = POSE_W + PW + 2;

  logic                 en;
  logic [CFG_W-1:0]     pose [NUM_REGS];
  item_ctl_t            ctl_bp;
  item_ctl_t            ctl_tr;
  item_ctl_t            ctl_dv;
  logic signed [PW-1:0] p0;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic signed [AW-1:0] acc [4];
  logic signed [AW-1:0] num [NUM_LANES];
  logic [OUT_W-1:0]     quo [NUM_LANES];

  assign en       = !(ctl_dv.vld && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        pose[i] <= pose_reset(i);
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      pose[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  dpw_backproj #(
    .COORD_BITS(COORD_BITS),
    .PW(PW)
  ) u_backproj (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_vld(in_valid),
    .col(pixel_col),
    .row(pixel_row),
    .depth(depth_mm),
    .ctl(ctl_bp),
    .p0(p0),
    .p1(p1),
    .p2(p2)
  );

  dpw_transform #(
    .PW(PW),
    .AW(AW)
  ) u_transform (
    .clk(clk),
    .rst(rst),
    .en(en),
    .ctl_in(ctl_bp),
    .p0(p0),
    .p1(p1),
    .p2(p2),
    .pose(pose),
    .ctl(ctl_tr),
    .acc(acc)
  );

  assign num[0] = acc[0];
  assign num[1] = acc[1];
  assign num[2] = acc[2];

  dpw_divider #(
    .AW(AW),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_divider (
    .clk(clk),
    .rst(rst),
    .en(en),
    .ctl_in(ctl_tr),
    .num(num),
    .den(acc[3]),
    .ctl(ctl_dv),
    .quo(quo)
  );

  assign out_valid   = ctl_dv.vld;
  assign point_valid = ctl_dv.pv;
  assign world_x     = quo[0];
  assign world_y     = quo[1];
  assign world_z     = quo[2];

endmodule

// ===== hdl/dpw_checker.sv =====
// ----------------------------------------------------------------------------
// dpw_checker
// Port-level checks of the depth pixel to world point core.
// ----------------------------------------------------------------------------
module dpw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         point_valid,
  input logic [dpw_pkg::OUT_W-1:0]    world_x,
  input logic [dpw_pkg::OUT_W-1:0]    world_y,
  input logic [dpw_pkg::OUT_W-1:0]    world_z
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result pending right after reset.");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("Input stall does not follow a blocked output transfer.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !point_valid) |-> (world_x == '0 && world_y == '0 && world_z == '0))
    else $error("Invalid point carries nonzero coordinates.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(world_x) && $stable(point_valid)))
    else $error("Stalled result changed.");

endmodule

bind depth_pixel_to_world_point_core dpw_checker u_dpw_checker (.*);
